/* hdl/sbd_pkg.sv */
// ----------------------------------------------------------------------------
// sbd_pkg
// Shared types, constants and small tables of the stop-bit order decoder.
// ----------------------------------------------------------------------------
package sbd_pkg;

  localparam int BYTES_PER_BEAT      = 8;
  localparam int BEAT_W              = 8 * BYTES_PER_BEAT;
  localparam int MSG_BYTES           = 2 * BYTES_PER_BEAT;
  localparam int POS_W               = $clog2(MSG_BYTES);
  localparam int PRICE_FRACTION_BITS = 10;

  // Stop-bit byte layout.
  localparam int       DATA_W    = 7;
  localparam logic [7:0] STOP_MASK = 8'h80;
  localparam logic [7:0] DATA_MASK = 8'h7F;

  // Field lengths in bytes.
  localparam int MANT_BYTES      = 3;
  localparam int SIZE_BYTES      = 2;
  localparam int ID_BYTES        = 5;
  localparam int FIELD_MAX_BYTES = 5;
  localparam int FIELD_W         = DATA_W * FIELD_MAX_BYTES;
  localparam int MANT_W          = DATA_W * MANT_BYTES;

  // The exponent byte sits right after the two skipped header bytes.
  localparam logic [POS_W-1:0] EXP_POS = POS_W'(2);

  // Exponent codes that map to a power of ten.
  localparam logic [DATA_W-1:0] EXP_ZERO   = 7'h00;
  localparam logic [DATA_W-1:0] EXP_MINUS1 = 7'h7F;
  localparam logic [DATA_W-1:0] EXP_MINUS2 = 7'h7E;
  localparam logic [DATA_W-1:0] EXP_MINUS3 = 7'h7D;

  // Divider constants: quotient by reciprocal with a 31-bit shift, remainder
  // fraction by a 20-bit shift.
  localparam int SCALE_W = 2;
  localparam int RECIP_W = 32;
  localparam int Q_SHIFT = 31;
  localparam int REM_W   = 10;
  localparam int R_SHIFT = 20;

  localparam int              PRICE_W   = 31;
  localparam logic [PRICE_W-1:0] PRICE_MAX = 31'h7FFF_FFFF;

  typedef logic [MSG_BYTES-1:0][7:0] msg_t;

  typedef struct packed {
    logic [FIELD_W-1:0] val;
    logic [POS_W-1:0]   pos;
  } field_t;

  typedef struct packed {
    logic [MANT_W-1:0]  mant;
    logic [SCALE_W-1:0] scale;
    logic               bad;
    logic [7:0]         order_size;
    logic [31:0]        order_id;
    logic [2:0]         order_type;
  } fields_t;

  typedef struct packed {
    logic [PRICE_W-1:0] price;
    logic [7:0]         order_size;
    logic [31:0]        order_id;
    logic [2:0]         order_type;
    logic               bad_exponent;
  } result_t;

  function automatic logic [REM_W-1:0] pow10(input logic [SCALE_W-1:0] k);
    logic [REM_W-1:0] d;
    case (k)
      2'd0:    d = 10'd1;
      2'd1:    d = 10'd10;
      2'd2:    d = 10'd100;
      default: d = 10'd1000;
    endcase
    return d;
  endfunction

  // ceil(2^31 / 10^k)
  function automatic logic [RECIP_W-1:0] recip(input logic [SCALE_W-1:0] k);
    logic [RECIP_W-1:0] m;
    case (k)
      2'd0:    m = 32'd2147483648;
      2'd1:    m = 32'd214748365;
      2'd2:    m = 32'd21474837;
      default: m = 32'd2147484;
    endcase
    return m;
  endfunction

endpackage

/* hdl/sbd_beat_if.sv */
// ----------------------------------------------------------------------------
// sbd_beat_if
// Beat channel: one 64-bit message word with a last flag per handshake.
// ----------------------------------------------------------------------------
interface sbd_beat_if;
  logic                       valid;
  logic                       ready;
  logic [sbd_pkg::BEAT_W-1:0] beat_data;
  logic                       beat_last;

  modport source (output valid, beat_data, beat_last, input ready);
  modport sink   (input valid, beat_data, beat_last, output ready);
endinterface

/* hdl/sbd_result_if.sv */
// ----------------------------------------------------------------------------
// sbd_result_if
// Result channel: one decoded order per handshake.
// ----------------------------------------------------------------------------
interface sbd_result_if;
  logic                        valid;
  logic                        ready;
  logic [sbd_pkg::PRICE_W-1:0] price;
  logic [7:0]                  order_size;
  logic [31:0]                 order_id;
  logic [2:0]                  order_type;
  logic                        bad_exponent;

  modport source (output valid, price, order_size, order_id, order_type, bad_exponent,
                  input ready);
  modport sink   (input valid, price, order_size, order_id, order_type, bad_exponent,
                  output ready);
endinterface

/* hdl/stop_bit_order_message_decoder_core.sv */
// ----------------------------------------------------------------------------
// stop_bit_order_message_decoder_core
// Collects message beats and decodes one stop-bit encoded order per message.
// ----------------------------------------------------------------------------
// The block takes one 64-bit word per clock on the beat channel whenever
// its message latch is empty or can pass its message on, and never needs a
// gap between messages. It keeps the first word of a message and the
// current later word; on the word marked last it latches the 16-byte
// message in the message latch and moves it on through field decode,
// quotient, remainder and the result register. Each of those stages holds
// one message and moves on whenever the stage after it can take it, so a
// stalled result channel only backs up the pipeline once every stage is
// full. A one-word message reads its upper eight bytes as zero; an exponent
// other than 0 to -3 sets bad_exponent and forces the price to zero.
module stop_bit_order_message_decoder_core #(
  parameter int PRICE_FRACTION_BITS = sbd_pkg::PRICE_FRACTION_BITS
) (
  input  logic          clk,
  input  logic          rst_n,
  sbd_beat_if.sink      in_beat,
  sbd_result_if.source  out_result
);

  logic                       inside_r;
  logic [sbd_pkg::BEAT_W-1:0] first_r;
  sbd_pkg::msg_t              msg_r;
  logic                       msg_vld_r;
  logic                       msg_rdy;
  logic                       accept;
  logic [sbd_pkg::BEAT_W-1:0] lo_beat;
  logic [sbd_pkg::BEAT_W-1:0] hi_beat;
  sbd_pkg::fields_t           fld;
  logic                       fld_vld;
  logic                       fld_rdy;
  sbd_pkg::result_t           res;
  logic                       res_vld;
  logic                       a_rdy;

  assign a_rdy         = !msg_vld_r || msg_rdy;
  assign in_beat.ready = rst_n && a_rdy;
  assign accept        = in_beat.valid && in_beat.ready;

  // A first word stands alone until a later word arrives.
  assign lo_beat = inside_r ? first_r : in_beat.beat_data;
  assign hi_beat = inside_r ? in_beat.beat_data : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inside_r  <= 1'b0;
      msg_vld_r <= 1'b0;
    end else begin
      if (accept) begin
        inside_r <= !in_beat.beat_last;
      end
      if (a_rdy) begin
        msg_vld_r <= accept && in_beat.beat_last;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && !inside_r) begin
      first_r <= in_beat.beat_data;
    end
    if (accept && in_beat.beat_last) begin
      msg_r <= {hi_beat, lo_beat};
    end
  end

  sbd_decode u_decode (
    .clk     (clk),
    .rst_n   (rst_n),
    .msg     (msg_r),
    .msg_vld (msg_vld_r),
    .msg_rdy (msg_rdy),
    .fld     (fld),
    .fld_vld (fld_vld),
    .fld_rdy (fld_rdy)
  );

  sbd_price #(
    .PRICE_FRACTION_BITS (PRICE_FRACTION_BITS)
  ) u_price (
    .clk     (clk),
    .rst_n   (rst_n),
    .fld     (fld),
    .fld_vld (fld_vld),
    .fld_rdy (fld_rdy),
    .res     (res),
    .res_vld (res_vld),
    .res_rdy (out_result.ready)
  );

  assign out_result.valid        = res_vld;
  assign out_result.price        = res.price;
  assign out_result.order_size   = res.order_size;
  assign out_result.order_id     = res.order_id;
  assign out_result.order_type   = res.order_type;
  assign out_result.bad_exponent = res.bad_exponent;

  // A last word always closes the message.
  a_last_closes: assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_beat.beat_last |=> !inside_r)
    else $error("message still open after its last word");

  // A message of one word carries zero upper bytes.
  a_single_hi_zero: assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_beat.beat_last && !inside_r |=>
      msg_vld_r && (msg_r[sbd_pkg::MSG_BYTES-1:sbd_pkg::BYTES_PER_BEAT] == '0))
    else $error("one-word message latched nonzero upper bytes");

  // An empty message latch never blocks the beat channel.
  a_empty_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !msg_vld_r |-> in_beat.ready)
    else $error("beat channel blocked with an empty message latch");

  // A bad exponent forces the price to zero.
  a_bad_price: assert property (@(posedge clk) disable iff (!rst_n)
    out_result.valid && out_result.bad_exponent |-> (out_result.price == '0))
    else $error("nonzero price with a bad exponent");

endmodule

/* hdl/sbd_decode.sv */
// ----------------------------------------------------------------------------
// sbd_decode
// Walks the stop-bit fields of a 16-byte message and registers them.
// ----------------------------------------------------------------------------
module sbd_decode (
  input  logic              clk,
  input  logic              rst_n,
  input  sbd_pkg::msg_t     msg,
  input  logic              msg_vld,
  output logic              msg_rdy,
  output sbd_pkg::fields_t  fld,
  output logic              fld_vld,
  input  logic              fld_rdy
);

  // Reads up to max_bytes bytes of one field; the last byte is taken whether
  // or not its stop bit is set.
  function automatic sbd_pkg::field_t take_field(input sbd_pkg::msg_t m,
                                                 input logic [sbd_pkg::POS_W-1:0] p,
                                                 input int unsigned max_bytes);
    sbd_pkg::field_t f;
    logic            done;
    logic [7:0]      b;
    f.val = '0;
    f.pos = p;
    done  = 1'b0;
    for (int unsigned n = 1; n < sbd_pkg::FIELD_MAX_BYTES; n++) begin
      b = m[f.pos];
      if ((n < max_bytes) && !done) begin
        if ((b & sbd_pkg::STOP_MASK) != 8'h00) begin
          done = 1'b1;
        end else begin
          f.val = {f.val[sbd_pkg::FIELD_W-sbd_pkg::DATA_W-1:0],
                   b[sbd_pkg::DATA_W-1:0]};
          f.pos = f.pos + 1'b1;
        end
      end
    end
    b     = m[f.pos] & sbd_pkg::DATA_MASK;
    f.val = {f.val[sbd_pkg::FIELD_W-sbd_pkg::DATA_W-1:0], b[sbd_pkg::DATA_W-1:0]};
    f.pos = f.pos + 1'b1;
    return f;
  endfunction

  sbd_pkg::fields_t fld_nxt;
  sbd_pkg::fields_t fld_r;
  sbd_pkg::field_t  mant_f;
  sbd_pkg::field_t  size_f;
  sbd_pkg::field_t  id_f;
  logic [7:0]       exp_byte;
  logic             vld_r;

  always_comb begin
    exp_byte = msg[sbd_pkg::EXP_POS];
    fld_nxt  = '0;
    unique case (exp_byte[sbd_pkg::DATA_W-1:0])
      sbd_pkg::EXP_ZERO:   fld_nxt.scale = 2'd0;
      sbd_pkg::EXP_MINUS1: fld_nxt.scale = 2'd1;
      sbd_pkg::EXP_MINUS2: fld_nxt.scale = 2'd2;
      sbd_pkg::EXP_MINUS3: fld_nxt.scale = 2'd3;
      default:             fld_nxt.bad   = 1'b1;
    endcase

    mant_f = take_field(msg, sbd_pkg::EXP_POS + 1'b1, sbd_pkg::MANT_BYTES);
    size_f = take_field(msg, mant_f.pos, sbd_pkg::SIZE_BYTES);
    id_f   = take_field(msg, size_f.pos, sbd_pkg::ID_BYTES);

    fld_nxt.mant       = mant_f.val[sbd_pkg::MANT_W-1:0];
    fld_nxt.order_size = size_f.val[7:0];
    fld_nxt.order_id   = id_f.val[31:0];
    fld_nxt.order_type = msg[id_f.pos][2:0];
  end

  assign msg_rdy = !vld_r || fld_rdy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (msg_rdy) begin
      vld_r <= msg_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (msg_rdy && msg_vld) begin
      fld_r <= fld_nxt;
    end
  end

  assign fld     = fld_r;
  assign fld_vld = vld_r;

endmodule

/* hdl/sbd_price.sv */
// ----------------------------------------------------------------------------
// sbd_price
// Scales the mantissa by a power of ten into fixed point: quotient by
// reciprocal, remainder, remainder fraction, then saturating sum.
// ----------------------------------------------------------------------------
module sbd_price #(
  parameter int PRICE_FRACTION_BITS = sbd_pkg::PRICE_FRACTION_BITS
) (
  input  logic              clk,
  input  logic              rst_n,
  input  sbd_pkg::fields_t  fld,
  input  logic              fld_vld,
  output logic              fld_rdy,
  output sbd_pkg::result_t  res,
  output logic              res_vld,
  input  logic              res_rdy
);

  localparam int F      = PRICE_FRACTION_BITS;
  localparam int M2_W   = F + sbd_pkg::R_SHIFT + 1;
  localparam int SUM_W  = sbd_pkg::MANT_W + F + 1;
  localparam int CMP_W  = (SUM_W > sbd_pkg::PRICE_W) ? SUM_W : sbd_pkg::PRICE_W;
  localparam logic [63:0] M2_ONE  = 64'd1 << (F + sbd_pkg::R_SHIFT);
  localparam logic [63:0] M2_TEN  = (M2_ONE + 64'd9) / 64'd10;
  localparam logic [63:0] M2_HUND = (M2_ONE + 64'd99) / 64'd100;
  localparam logic [63:0] M2_THOU = (M2_ONE + 64'd999) / 64'd1000;

  localparam int P1_W = sbd_pkg::MANT_W + sbd_pkg::RECIP_W;
  localparam int QD_W = sbd_pkg::MANT_W + sbd_pkg::REM_W;
  localparam int P2_W = sbd_pkg::REM_W + M2_W;

  // Stage 1: quotient.
  sbd_pkg::fields_t            f1_r;
  logic [sbd_pkg::MANT_W-1:0]  q1_r;
  logic                        v1_r;
  logic [P1_W-1:0]             prod1;
  // Stage 2: remainder.
  sbd_pkg::fields_t            f2_r;
  logic [sbd_pkg::MANT_W-1:0]  q2_r;
  logic [sbd_pkg::REM_W-1:0]   rem2_r;
  logic                        v2_r;
  logic [QD_W-1:0]             qd;
  logic [QD_W-1:0]             diff;
  // Stage 3: fraction and sum into the result register.
  logic [M2_W-1:0]             m2;
  logic [P2_W-1:0]             prod2;
  logic [SUM_W-1:0]            sum;
  logic [CMP_W-1:0]            sum_ext;
  sbd_pkg::result_t            res_nxt;
  sbd_pkg::result_t            res_r;
  logic                        vo_r;
  logic                        rdy1;
  logic                        rdy2;
  logic                        rdy3;

  assign rdy3    = !vo_r || res_rdy;
  assign rdy2    = !v2_r || rdy3;
  assign rdy1    = !v1_r || rdy2;
  assign fld_rdy = rdy1;

  assign prod1 = P1_W'(fld.mant) * P1_W'(sbd_pkg::recip(fld.scale));
  assign qd    = QD_W'(q1_r) * QD_W'(sbd_pkg::pow10(f1_r.scale));
  assign diff  = QD_W'(f1_r.mant) - qd;

  always_comb begin
    case (f2_r.scale)
      2'd0:    m2 = M2_W'(M2_ONE);
      2'd1:    m2 = M2_W'(M2_TEN);
      2'd2:    m2 = M2_W'(M2_HUND);
      default: m2 = M2_W'(M2_THOU);
    endcase
    prod2   = P2_W'(rem2_r) * P2_W'(m2);
    sum     = SUM_W'({q2_r, {F{1'b0}}}) + SUM_W'(prod2[sbd_pkg::R_SHIFT +: F]);
    sum_ext = CMP_W'(sum);

    res_nxt.order_size   = f2_r.order_size;
    res_nxt.order_id     = f2_r.order_id;
    res_nxt.order_type   = f2_r.order_type;
    res_nxt.bad_exponent = f2_r.bad;
    if (f2_r.bad) begin
      res_nxt.price = '0;
    end else if (sum_ext > CMP_W'(sbd_pkg::PRICE_MAX)) begin
      res_nxt.price = sbd_pkg::PRICE_MAX;
    end else begin
      res_nxt.price = sum_ext[sbd_pkg::PRICE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      vo_r <= 1'b0;
    end else begin
      if (rdy1) begin
        v1_r <= fld_vld;
      end
      if (rdy2) begin
        v2_r <= v1_r;
      end
      if (rdy3) begin
        vo_r <= v2_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1 && fld_vld) begin
      f1_r <= fld;
      q1_r <= prod1[sbd_pkg::Q_SHIFT +: sbd_pkg::MANT_W];
    end
    if (rdy2 && v1_r) begin
      f2_r   <= f1_r;
      q2_r   <= q1_r;
      rem2_r <= diff[sbd_pkg::REM_W-1:0];
    end
    if (rdy3 && v2_r) begin
      res_r <= res_nxt;
    end
  end

  assign res     = res_r;
  assign res_vld = vo_r;

endmodule

/* verif/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// Drives message words into the stop-bit order decoder and checks every
// decoded order against a cycle-free prediction of the same decode.
// Directed messages cover:
//   - one-word messages
//   - messages longer than two words
//   - each valid exponent and rejected exponents
//   - fields at full length without a stop bit
// A random mix of well-formed and noise messages follows. Both channels
// stall at random, the result side once holds off for a long stretch, and
// the sender drains the pipeline between phases.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int FRAC         = sbd_pkg::PRICE_FRACTION_BITS;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int HALF_BEATS   = 540;
  localparam int HOLD_AT      = 300;
  localparam int HOLD_CYCLES  = 150;
  localparam int SEND_QUIET_LO = 450;
  localparam int SEND_QUIET_HI = 700;
  localparam int RECV_QUIET_LO = 500;
  localparam int RECV_QUIET_HI = 760;
  localparam int IDLE_PCT     = 9;

  typedef struct {
    logic [sbd_pkg::BEAT_W-1:0] data;
    logic                       is_last;
  } beat_t;

  logic clk = 1'b0;
  logic rst_n;

  sbd_beat_if   beat_ch ();
  sbd_result_if order_ch ();

  stop_bit_order_message_decoder_core #(
    .PRICE_FRACTION_BITS(FRAC)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_beat   (beat_ch),
    .out_result(order_ch)
  );

  always #5 clk = ~clk;

  beat_t            beats_pending[$];
  sbd_pkg::result_t orders_due[$];
  logic [63:0]      first_word;
  logic [63:0]      later_word;
  bit               mid_message;
  int unsigned      beats_queued = 0;
  int unsigned      beats_taken = 0;
  int unsigned      mismatches = 0;
  int unsigned      cycles = 0;
  int unsigned      hold_left;
  bit               hold_done;

  task automatic report(input string msg);
    $display("MISMATCH at %0t: %s", $realtime, msg);
    mismatches++;
  endtask

  // Reads one stop-bit field; the byte at the length limit is taken even
  // without its stop bit.
  function automatic longint unsigned take_stop_field(input logic [127:0] msg,
                                                      ref int unsigned pos,
                                                      input int unsigned max_len);
    longint unsigned acc;
    logic [7:0]      b;
    int unsigned     n;
    acc = 0;
    for (n = 1; n < max_len; n++) begin
      b = msg[8*(pos%sbd_pkg::MSG_BYTES) +: 8];
      if ((b & sbd_pkg::STOP_MASK) != 0) break;
      acc = (acc << 7) | longint'(b & sbd_pkg::DATA_MASK);
      pos++;
    end
    b = msg[8*(pos%sbd_pkg::MSG_BYTES) +: 8];
    acc = (acc << 7) | longint'(b & sbd_pkg::DATA_MASK);
    pos++;
    return acc;
  endfunction

  function automatic sbd_pkg::result_t decode_order(input logic [63:0] lo,
                                                    input logic [63:0] hi);
    logic [127:0]               msg;
    logic [sbd_pkg::DATA_W-1:0] expo;
    int unsigned                pos;
    longint unsigned            mant, qty, ident, quot, divisor;
    bit                         bad;
    sbd_pkg::result_t           r;
    msg = {hi, lo};
    expo = msg[8*int'(sbd_pkg::EXP_POS) +: sbd_pkg::DATA_W];
    pos = int'(sbd_pkg::EXP_POS) + 1;
    bad = 1'b0;
    divisor = 1;
    case (expo)
      sbd_pkg::EXP_ZERO:   divisor = 1;
      sbd_pkg::EXP_MINUS1: divisor = 10;
      sbd_pkg::EXP_MINUS2: divisor = 100;
      sbd_pkg::EXP_MINUS3: divisor = 1000;
      default:             bad = 1'b1;
    endcase
    mant  = take_stop_field(msg, pos, sbd_pkg::MANT_BYTES);
    qty   = take_stop_field(msg, pos, sbd_pkg::SIZE_BYTES);
    ident = take_stop_field(msg, pos, sbd_pkg::ID_BYTES);
    if (bad) begin
      quot = 0;
    end else begin
      quot = (mant << FRAC) / divisor;
      if (quot > longint'(sbd_pkg::PRICE_MAX)) quot = longint'(sbd_pkg::PRICE_MAX);
    end
    r.price        = quot[sbd_pkg::PRICE_W-1:0];
    r.order_size   = qty[7:0];
    r.order_id     = ident[31:0];
    r.order_type   = msg[8*(pos%sbd_pkg::MSG_BYTES) +: 3];
    r.bad_exponent = bad;
    return r;
  endfunction

  // Lays out exponent, mantissa, size, id and type bytes over a filler message;
  // a field shorter than its limit ends on a stop bit, a full-length one only with stop_at_limit.
  function automatic logic [127:0] encode_order(input logic [127:0] filler,
                                                input logic [7:0] expo_byte,
                                                input int unsigned mlen,
                                                input longint unsigned mval,
                                                input int unsigned slen,
                                                input longint unsigned sval,
                                                input int unsigned ilen,
                                                input longint unsigned ival,
                                                input bit stop_at_limit,
                                                input logic [7:0] kind_byte);
    logic [127:0]    m;
    int unsigned     pos, f, k, len, lim;
    longint unsigned v, part;
    bit              stop;
    m = filler;
    m[8*int'(sbd_pkg::EXP_POS) +: 8] = expo_byte;
    pos = int'(sbd_pkg::EXP_POS) + 1;
    for (f = 0; f < 3; f++) begin
      case (f)
        0:       begin len = mlen; v = mval; lim = sbd_pkg::MANT_BYTES; end
        1:       begin len = slen; v = sval; lim = sbd_pkg::SIZE_BYTES; end
        default: begin len = ilen; v = ival; lim = sbd_pkg::ID_BYTES; end
      endcase
      for (k = 0; k < len; k++) begin
        part = v >> (7 * (len - 1 - k));
        stop = (k == len - 1) && (len < lim || stop_at_limit);
        m[8*pos +: 8] = {stop, part[6:0]};
        pos++;
      end
    end
    m[8*pos +: 8] = kind_byte;
    return m;
  endfunction

  // A message of nwords words: the first carries bytes 0..7, the final one
  // bytes 8..15, and any words between them carry junk the decoder drops.
  task automatic push_message(input logic [127:0] m, input int unsigned nwords);
    beat_t       b;
    int unsigned k;
    b.data = m[63:0];
    b.is_last = (nwords == 1);
    beats_pending.push_back(b);
    for (k = 2; k < nwords; k++) begin
      b.data = {$urandom, $urandom};
      b.is_last = 1'b0;
      beats_pending.push_back(b);
    end
    if (nwords > 1) begin
      b.data = m[127:64];
      b.is_last = 1'b1;
      beats_pending.push_back(b);
    end
    beats_queued += nwords;
  endtask

  task automatic add_random_messages(input int unsigned goal);
    logic [127:0]               m;
    logic [sbd_pkg::DATA_W-1:0] expo;
    int unsigned                nwords, pick;
    while (beats_queued < goal) begin
      pick = $urandom_range(0, 9);
      if (pick < 2)      nwords = 1;
      else if (pick < 8) nwords = 2;
      else if (pick < 9) nwords = 3;
      else               nwords = $urandom_range(4, 6);
      if ($urandom_range(0, 6) == 0) begin
        m = {$urandom, $urandom, $urandom, $urandom};
      end else begin
        pick = $urandom_range(0, 9);
        case (pick)
          0, 4:    expo = sbd_pkg::EXP_ZERO;
          1, 5:    expo = sbd_pkg::EXP_MINUS1;
          2, 6:    expo = sbd_pkg::EXP_MINUS2;
          3:       expo = sbd_pkg::EXP_MINUS3;
          default: expo = sbd_pkg::DATA_W'($urandom);
        endcase
        m = encode_order({$urandom, $urandom, $urandom, $urandom},
                         {1'($urandom_range(0, 1)), expo},
                         $urandom_range(1, sbd_pkg::MANT_BYTES), {$urandom, $urandom},
                         $urandom_range(1, sbd_pkg::SIZE_BYTES), {$urandom, $urandom},
                         $urandom_range(1, sbd_pkg::ID_BYTES), {$urandom, $urandom},
                         1'($urandom_range(0, 1)), 8'($urandom));
      end
      push_message(m, nwords);
    end
  endtask

  task automatic wait_drained();
    while (beats_pending.size() != 0 || beat_ch.valid || orders_due.size() != 0)
      @(posedge clk);
  endtask

  // Sender: offers queued words and predicts the order each last word yields.
  always @(posedge clk) begin : drive
    bit gap;
    if (!rst_n) begin
      beat_ch.valid     <= 1'b0;
      beat_ch.beat_data <= '0;
      beat_ch.beat_last <= 1'b0;
      first_word  = '0;
      later_word  = '0;
      mid_message = 1'b0;
    end else begin
      if (beat_ch.valid && beat_ch.ready) begin
        beats_taken++;
        if (!mid_message) begin
          first_word = beat_ch.beat_data;
          later_word = '0;
          if (beat_ch.beat_last) orders_due.push_back(decode_order(first_word, later_word));
          else mid_message = 1'b1;
        end else begin
          later_word = beat_ch.beat_data;
          if (beat_ch.beat_last) begin
            mid_message = 1'b0;
            orders_due.push_back(decode_order(first_word, later_word));
          end
        end
      end
      gap = ($urandom_range(0, 99) < IDLE_PCT) &&
            !(beats_taken >= SEND_QUIET_LO && beats_taken < SEND_QUIET_HI);
      if (!beat_ch.valid || beat_ch.ready) begin
        if (beats_pending.size() != 0 && !gap) begin
          beat_ch.valid     <= 1'b1;
          beat_ch.beat_data <= beats_pending[0].data;
          beat_ch.beat_last <= beats_pending[0].is_last;
          void'(beats_pending.pop_front());
        end else begin
          beat_ch.valid <= 1'b0;
        end
      end
    end
  end

  // One long hold-off on the result side, so the pipeline fills and the
  // input channel backs up while words keep being offered.
  always @(posedge clk) begin
    if (!rst_n) begin
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (!hold_done && beats_taken >= HOLD_AT) begin
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // Receiver: checks every accepted order against the oldest prediction.
  always @(posedge clk) begin : watch
    sbd_pkg::result_t want;
    bit               gap;
    if (!rst_n) begin
      order_ch.ready <= 1'b0;
    end else begin
      if (order_ch.valid && order_ch.ready) begin
        if (orders_due.size() == 0) begin
          report($sformatf("unexpected order: price %0h id %0h", order_ch.price,
                           order_ch.order_id));
        end else begin
          want = orders_due.pop_front();
          if (order_ch.price !== want.price)
            report($sformatf("price: expected %0h, got %0h", want.price, order_ch.price));
          if (order_ch.order_size !== want.order_size)
            report($sformatf("order_size: expected %0h, got %0h", want.order_size,
                             order_ch.order_size));
          if (order_ch.order_id !== want.order_id)
            report($sformatf("order_id: expected %0h, got %0h", want.order_id,
                             order_ch.order_id));
          if (order_ch.order_type !== want.order_type)
            report($sformatf("order_type: expected %0h, got %0h", want.order_type,
                             order_ch.order_type));
          if (order_ch.bad_exponent !== want.bad_exponent)
            report($sformatf("bad_exponent: expected %0b, got %0b", want.bad_exponent,
                             order_ch.bad_exponent));
        end
      end
      gap = ($urandom_range(0, 99) < IDLE_PCT) &&
            !(beats_taken >= RECV_QUIET_LO && beats_taken < RECV_QUIET_HI);
      order_ch.ready <= (hold_left == 0) && !gap;
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin : stimulus
    rst_n = 1'b0;
    beat_ch.valid = 1'b0;
    beat_ch.beat_data = '0;
    beat_ch.beat_last = 1'b0;
    order_ch.ready = 1'b0;

    // One-word messages, all zeros and all ones.
    push_message('0, 1);
    push_message('1, 1);
    // Largest mantissa at exponent -3; every field at full length, no stop bits.
    push_message(encode_order('0, {1'b1, sbd_pkg::EXP_MINUS3}, 3, 64'h1F_FFFF, 2,
                              64'h3FFF, 5, 64'h7_FFFF_FFFF, 1'b0, 8'h07), 2);
    // Shortest fields at exponent -2.
    push_message(encode_order('1, {1'b1, sbd_pkg::EXP_MINUS2}, 1, 0, 1, 0, 1, 0,
                              1'b1, 8'h00), 2);
    push_message(encode_order('0, {1'b0, sbd_pkg::EXP_MINUS1}, 2, 12345, 1, 5, 3,
                              99999, 1'b1, 8'h05), 2);
    push_message(encode_order('0, {1'b1, sbd_pkg::EXP_ZERO}, 3, 1000, 2, 300, 4,
                              123456, 1'b1, 8'h03), 2);
    // Exponents just outside the accepted range.
    push_message(encode_order('0, 8'h81, 2, 777, 1, 9, 2, 4321, 1'b1, 8'h06), 2);
    push_message(encode_order('0, 8'hFC, 3, 65432, 2, 1000, 5, 64'h1_2345_6789,
                              1'b1, 8'h01), 2);
    // Longer messages keep only the latest later word.
    push_message(encode_order('1, {1'b1, sbd_pkg::EXP_MINUS1}, 2, 500, 2, 40, 3, 8888,
                              1'b1, 8'h02), 3);
    push_message(encode_order('0, {1'b1, sbd_pkg::EXP_MINUS2}, 3, 99999, 1, 17, 5,
                              64'hABCDEF, 1'b1, 8'h04), 4);
    push_message('1, 2);

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    wait_drained();

    add_random_messages(beats_queued + HALF_BEATS);
    wait_drained();
    add_random_messages(beats_queued + HALF_BEATS);
    wait_drained();
    repeat (20) @(posedge clk);

    if (orders_due.size() != 0)
      report($sformatf("%0d predicted orders never arrived", orders_due.size()));
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
